// ===== src/sso_pkg.sv =====
`timescale 1ns / 1ps
// sso_pkg: shared widths, codes and types for the sorted set operations unit
// no dependencies; used by src/sorted_set_operations_unit.sv
package sso_pkg;

    localparam int VALUE_W        = 32;
    localparam int ACTION_W       = 2;
    localparam int OP_MODE_W      = 2;
    localparam int RESULT_COUNT_W = 6;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 2;
    localparam int LIST_DEPTH_DEF = 16;

    // item action codes
    localparam logic [ACTION_W-1:0] ACT_APPEND_A = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND_B = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RUN      = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_OP_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEDUPE  = 2'd1;

    typedef enum logic [OP_MODE_W-1:0] {
        OP_UNION     = 2'd0,
        OP_INTERSECT = 2'd1,
        OP_SUBSET    = 2'd2,
        OP_DEDUPE    = 2'd3
    } op_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_MERGE  = 3'd1,
        ST_PRIME  = 3'd2,
        ST_OUT    = 3'd3,
        ST_SINGLE = 3'd4
    } state_t;

endpackage

// ===== src/sorted_set_operations_unit.sv =====
`timescale 1ns / 1ps
// sorted_set_operations_unit: two list memories, merge sequencer, result memory
// depends on src/sso_pkg.sv
//
// Usage: an append item (action 0 or 1) gives no result.
// A run item (action 2) makes the block busy while a two-pointer merge walks
// list A and list B out of their memories, one pointer step per cycle.
// Results are first written into a result memory, so that every result can
// carry the final count; then, after the prime state for the result memory
// read, they are streamed one per cycle on result_valid. A run whose result
// list is empty, and any subset test, gives a single result marked empty_res
// in the cycle after the merge ends.
// The receiver cannot stall results: each is valid for exactly one cycle.
// Configuration writes are always ready and must only be made while idle.
module sorted_set_operations_unit #(
    parameter int LIST_DEPTH = sso_pkg::LIST_DEPTH_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // command channel
    input  logic                                     start,
    output logic                                     busy,
    input  logic [sso_pkg::ACTION_W-1:0]             action,
    input  logic signed [sso_pkg::VALUE_W-1:0]       value,
    // configuration write channel
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [sso_pkg::CFG_INDEX_W-1:0]          cfg_index,
    input  logic [sso_pkg::CFG_DATA_W-1:0]           cfg_data,
    // result strobe and payload
    output logic                                     result_valid,
    output logic signed [sso_pkg::VALUE_W-1:0]       value_res,
    output logic                                     is_subset,
    output logic [sso_pkg::RESULT_COUNT_W-1:0]       result_count,
    output logic                                     empty_res,
    output logic                                     overflow,
    output logic                                     last
);

    // list index, list count, result index and result count widths
    localparam int IDX_W  = $clog2(LIST_DEPTH);
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int RES_D  = 2 * LIST_DEPTH;
    localparam int RIDX_W = $clog2(RES_D);
    localparam int KW     = $clog2(RES_D + 1);

    // storage: lists and the result buffer, registered synchronous reads
    logic signed [sso_pkg::VALUE_W-1:0] mem_a [LIST_DEPTH];
    logic signed [sso_pkg::VALUE_W-1:0] mem_b [LIST_DEPTH];
    logic signed [sso_pkg::VALUE_W-1:0] mem_res [RES_D];

    logic signed [sso_pkg::VALUE_W-1:0] rd_a_reg;
    logic signed [sso_pkg::VALUE_W-1:0] rd_b_reg;
    logic signed [sso_pkg::VALUE_W-1:0] rd_res_reg;

    // control and configuration state
    sso_pkg::state_t   state_reg, state_next;
    sso_pkg::op_mode_t op_mode_reg;
    logic              dedupe_reg;
    logic [CNT_W-1:0]  count_a_reg, count_b_reg;
    logic              overflow_reg;

    // merge pointers and bookkeeping
    logic [CNT_W-1:0]                   ia_reg, ia_next, ib_reg, ib_next;
    logic signed [sso_pkg::VALUE_W-1:0] prev_a_reg, prev_a_next;
    logic signed [sso_pkg::VALUE_W-1:0] prev_b_reg, prev_b_next;
    logic [KW-1:0]                      k_reg, k_next, j_reg, j_next;
    logic                               subset_reg, subset_next;

    // one merge step
    logic                               a_live, b_live, a_dup, b_dup;
    logic                               dd_a, dd_b, b_lt_a, heads_eq;
    logic                               step_adv_a, step_adv_b, step_emit, merge_done;
    logic signed [sso_pkg::VALUE_W-1:0] step_val;

    logic             item_acc, load_a, load_b, run_acc, out_last;
    logic [IDX_W-1:0] rd_addr_a, rd_addr_b;
    logic [KW-1:0]    j_inc;
    logic [RIDX_W-1:0] rd_addr_res;

    assign item_acc = start && !busy;
    assign load_a   = item_acc && (action == sso_pkg::ACT_APPEND_A);
    assign load_b   = item_acc && (action == sso_pkg::ACT_APPEND_B);
    assign run_acc  = item_acc && (action == sso_pkg::ACT_RUN);
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg <= sso_pkg::OP_UNION;
            dedupe_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sso_pkg::REG_OP_MODE:
                    op_mode_reg <= sso_pkg::op_mode_t'(cfg_data[sso_pkg::OP_MODE_W-1:0]);
                sso_pkg::REG_DEDUPE:
                    dedupe_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // list fill counts and the sticky dropped-append flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg  <= '0;
            count_b_reg  <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            if (load_a)
            begin
                if (count_a_reg < CNT_W'(LIST_DEPTH))
                    count_a_reg <= count_a_reg + CNT_W'(1);
                else
                    overflow_reg <= 1'b1;
            end
            if (load_b)
            begin
                if (count_b_reg < CNT_W'(LIST_DEPTH))
                    count_b_reg <= count_b_reg + CNT_W'(1);
                else
                    overflow_reg <= 1'b1;
            end
        end
    end

    // read addresses follow the next pointers so the registered read data lines
    // up with the pointer registers
    assign rd_addr_a = (ia_next < CNT_W'(LIST_DEPTH)) ? ia_next[IDX_W-1:0] : '0;
    assign rd_addr_b = (ib_next < CNT_W'(LIST_DEPTH)) ? ib_next[IDX_W-1:0] : '0;

    assign j_inc       = j_reg + KW'(1);
    assign rd_addr_res = (state_reg == sso_pkg::ST_OUT && j_inc < KW'(RES_D))
                         ? j_inc[RIDX_W-1:0] : '0;

    // list memories: written by appends, read by the merge
    always_ff @(posedge clk)
    begin
        if (load_a && count_a_reg < CNT_W'(LIST_DEPTH))
            mem_a[count_a_reg[IDX_W-1:0]] <= value;
        rd_a_reg <= mem_a[rd_addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (load_b && count_b_reg < CNT_W'(LIST_DEPTH))
            mem_b[count_b_reg[IDX_W-1:0]] <= value;
        rd_b_reg <= mem_b[rd_addr_b];
    end

    // result memory: written during the merge, read while streaming
    always_ff @(posedge clk)
    begin
        if (state_reg == sso_pkg::ST_MERGE && step_emit)
            mem_res[k_reg[RIDX_W-1:0]] <= step_val;
        rd_res_reg <= mem_res[rd_addr_res];
    end

    // one merge step on the current heads
    always_comb
    begin
        a_live   = ia_reg < count_a_reg;
        b_live   = ib_reg < count_b_reg;
        dd_a     = (op_mode_reg == sso_pkg::OP_UNION && dedupe_reg)
                   || op_mode_reg == sso_pkg::OP_DEDUPE;
        dd_b     = op_mode_reg == sso_pkg::OP_UNION && dedupe_reg;
        // a repeat equals the element just before it in the same list
        a_dup    = dd_a && ia_reg != '0 && rd_a_reg == prev_a_reg;
        b_dup    = dd_b && ib_reg != '0 && rd_b_reg == prev_b_reg;
        b_lt_a   = rd_b_reg < rd_a_reg;
        heads_eq = rd_a_reg == rd_b_reg;

        step_adv_a = 1'b0;
        step_adv_b = 1'b0;
        step_emit  = 1'b0;
        step_val   = rd_a_reg;
        merge_done = 1'b0;

        case (op_mode_reg)
            sso_pkg::OP_UNION:
            begin
                if ((a_live && a_dup) || (b_live && b_dup))
                begin
                    // drop repeats before comparing
                    step_adv_a = a_live && a_dup;
                    step_adv_b = b_live && b_dup;
                end
                else if (a_live && b_live)
                begin
                    step_emit = 1'b1;
                    if (heads_eq)
                    begin
                        step_adv_a = 1'b1;
                        step_adv_b = 1'b1;
                    end
                    else if (b_lt_a)
                    begin
                        step_adv_b = 1'b1;
                        step_val   = rd_b_reg;
                    end
                    else
                        step_adv_a = 1'b1;
                end
                else if (b_live)
                begin
                    step_emit  = 1'b1;
                    step_adv_b = 1'b1;
                    step_val   = rd_b_reg;
                end
                else if (a_live)
                begin
                    step_emit  = 1'b1;
                    step_adv_a = 1'b1;
                end
                else
                    merge_done = 1'b1;
            end
            sso_pkg::OP_INTERSECT:
            begin
                if (a_live && b_live)
                begin
                    if (heads_eq)
                    begin
                        step_emit  = 1'b1;
                        step_adv_a = 1'b1;
                        step_adv_b = 1'b1;
                    end
                    else if (b_lt_a)
                        step_adv_b = 1'b1;
                    else
                        step_adv_a = 1'b1;
                end
                else
                    merge_done = 1'b1;
            end
            sso_pkg::OP_SUBSET:
            begin
                // stops at the first element of A that B cannot match
                if (a_live && b_live && heads_eq)
                begin
                    step_adv_a = 1'b1;
                    step_adv_b = 1'b1;
                end
                else if (a_live && b_live && b_lt_a)
                    step_adv_b = 1'b1;
                else
                    merge_done = 1'b1;
            end
            default:
            begin
                // duplicate removal on A alone
                if (a_live)
                begin
                    step_adv_a = 1'b1;
                    step_emit  = !a_dup;
                end
                else
                    merge_done = 1'b1;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sso_pkg::ST_IDLE:
                if (run_acc)
                    state_next = sso_pkg::ST_MERGE;
            sso_pkg::ST_MERGE:
                if (merge_done)
                begin
                    if (op_mode_reg == sso_pkg::OP_SUBSET || k_reg == '0)
                        state_next = sso_pkg::ST_SINGLE;
                    else
                        state_next = sso_pkg::ST_PRIME;
                end
            sso_pkg::ST_PRIME:
                state_next = sso_pkg::ST_OUT;
            sso_pkg::ST_OUT:
                if (out_last)
                    state_next = sso_pkg::ST_IDLE;
            sso_pkg::ST_SINGLE:
                state_next = sso_pkg::ST_IDLE;
            default:
                state_next = sso_pkg::ST_IDLE;
        endcase
    end

    // pointer and counter updates
    always_comb
    begin
        ia_next     = '0;
        ib_next     = '0;
        prev_a_next = prev_a_reg;
        prev_b_next = prev_b_reg;
        k_next      = k_reg;
        j_next      = j_reg;
        subset_next = subset_reg;
        unique case (state_reg)
            sso_pkg::ST_IDLE:
                if (run_acc)
                begin
                    k_next      = '0;
                    j_next      = '0;
                    subset_next = 1'b0;
                end
            sso_pkg::ST_MERGE:
            begin
                ia_next = step_adv_a ? ia_reg + CNT_W'(1) : ia_reg;
                ib_next = step_adv_b ? ib_reg + CNT_W'(1) : ib_reg;
                if (step_adv_a)
                    prev_a_next = rd_a_reg;
                if (step_adv_b)
                    prev_b_next = rd_b_reg;
                if (step_emit)
                    k_next = k_reg + KW'(1);
                if (merge_done)
                    subset_next = op_mode_reg == sso_pkg::OP_SUBSET && !a_live;
            end
            sso_pkg::ST_OUT:
                j_next = j_inc;
            sso_pkg::ST_PRIME,
            sso_pkg::ST_SINGLE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sso_pkg::ST_IDLE;
            ia_reg     <= '0;
            ib_reg     <= '0;
            k_reg      <= '0;
            j_reg      <= '0;
            subset_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ia_reg     <= ia_next;
            ib_reg     <= ib_next;
            k_reg      <= k_next;
            j_reg      <= j_next;
            subset_reg <= subset_next;
        end
    end

    // previous heads are payload, no reset needed
    always_ff @(posedge clk)
    begin
        prev_a_reg <= prev_a_next;
        prev_b_reg <= prev_b_next;
    end

    // outputs
    assign out_last = j_reg == k_reg - KW'(1);

    always_comb
    begin
        busy         = state_reg != sso_pkg::ST_IDLE;
        overflow     = overflow_reg;
        result_valid = 1'b0;
        value_res    = '0;
        is_subset    = 1'b0;
        result_count = '0;
        empty_res    = 1'b0;
        last         = 1'b0;
        unique case (state_reg)
            sso_pkg::ST_OUT:
            begin
                result_valid = 1'b1;
                value_res    = rd_res_reg;
                result_count = sso_pkg::RESULT_COUNT_W'(k_reg);
                last         = out_last;
            end
            sso_pkg::ST_SINGLE:
            begin
                // empty list or subset verdict
                result_valid = 1'b1;
                is_subset    = subset_reg;
                empty_res    = 1'b1;
                last         = 1'b1;
            end
            sso_pkg::ST_IDLE,
            sso_pkg::ST_MERGE,
            sso_pkg::ST_PRIME:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // checks
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |=> !busy)
        else $error("block still busy after the last result");

    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_a_reg <= CNT_W'(LIST_DEPTH) && count_b_reg <= CNT_W'(LIST_DEPTH))
        else $error("list count beyond list depth");

    a_empty_has_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && empty_res |-> result_count == '0 && last)
        else $error("empty result carries a count or is not last");

    a_merge_progress: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sso_pkg::ST_MERGE && !merge_done |-> step_adv_a || step_adv_b)
        else $error("merge step made no progress");

endmodule

// ===== tb/sorted_set_operations_unit_test.sv =====
`timescale 1ns / 1ps
// sorted_set_operations_unit_test: self-checking bench for the sorted set operations unit
// fills lists A and B, runs each mode and checks every streamed result against a local model
// depends on src/sso_pkg.sv and src/sorted_set_operations_unit.sv
module sorted_set_operations_unit_test;
    import sso_pkg::*;

    localparam int DEPTH          = LIST_DEPTH_DEF;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 4 * DEPTH + 16; // longer than any merge plus stream
    localparam int CYCLE_LIMIT    = 500000;
    localparam int RANDOM_ITEMS   = 376;
    localparam int REPORT_LIMIT   = 10;

    // the one action code the block does not define
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef logic signed [VALUE_W-1:0] elem_t;
    typedef elem_t elem_list_t [2*DEPTH];

    localparam elem_t VAL_MIN = 32'sh8000_0000;
    localparam elem_t VAL_MAX = 32'sh7fff_ffff;

    // one streamed result as the block should present it
    typedef struct packed {
        elem_t                     elem;
        logic                      subset;
        logic [RESULT_COUNT_W-1:0] count;
        logic                      marked_empty;
        logic                      dropped;
        logic                      tail;
    } set_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [ACTION_W-1:0]       action;
    logic signed [VALUE_W-1:0] value;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      result_valid;
    logic signed [VALUE_W-1:0] value_res;
    logic                      is_subset;
    logic [RESULT_COUNT_W-1:0] result_count;
    logic                      empty_res;
    logic                      overflow;
    logic                      last;

    sorted_set_operations_unit #(
        .LIST_DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .value(value),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .result_valid(result_valid),
        .value_res(value_res),
        .is_subset(is_subset),
        .result_count(result_count),
        .empty_res(empty_res),
        .overflow(overflow),
        .last(last)
    );

    // bench copy of the block state and its registers
    elem_list_t mirror_a;
    elem_list_t mirror_b;
    int         len_a;
    int         len_b;
    logic       dropped_seen;
    op_mode_t   cur_mode;
    logic       cur_dedupe;

    // results still owed by the block, oldest first
    set_result_t set_results_due[$];

    int fail_count;
    int results_checked;
    int runs_sent;
    int appends_kept;
    int appends_dropped;
    int reg_writes;
    int cycle_count;
    int burst_left;
    bit start_high;

    always #5 clk = ~clk;

    // hard stop in case the block hangs or never produces an owed result
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, set_results_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
        begin
            $display("[%0t] %s", $time, msg);
        end
    endtask

    // result checker: the strobe lasts one cycle, so sample it at the edge that ends it
    always @(posedge clk)
    begin
        set_result_t want;
        if (rst_n && result_valid)
        begin
            if (set_results_due.size() == 0)
            begin
                note_failure($sformatf("unexpected result: value %0d count %0d empty %0b last %0b",
                                       value_res, result_count, empty_res, last));
            end
            else
            begin
                want = set_results_due.pop_front();
                results_checked++;
                if (value_res !== want.elem || is_subset !== want.subset
                    || result_count !== want.count || empty_res !== want.marked_empty
                    || overflow !== want.dropped || last !== want.tail)
                begin
                    note_failure($sformatf({"result mismatch: expected value %0d subset %0b ",
                        "count %0d empty %0b overflow %0b last %0b, got %0d %0b %0d %0b %0b %0b"},
                        want.elem, want.subset, want.count, want.marked_empty, want.dropped,
                        want.tail, value_res, is_subset, result_count, empty_res, overflow,
                        last));
                end
            end
        end
    end

    // copy a list keeping only the first of each run of equal neighbors
    function automatic int squeeze_repeats(input elem_list_t src, input int n,
                                           output elem_list_t dst);
        int kept;
        kept = 0;
        dst = src;
        for (int i = 0; i < n; i++)
        begin
            if (kept == 0 || dst[kept-1] != src[i])
            begin
                dst[kept] = src[i];
                kept++;
            end
        end
        return kept;
    endfunction

    function automatic void push_result(input elem_t elem, input logic subset, input int total,
                                        input logic marked_empty, input logic tail);
        set_result_t r;
        r.elem         = elem;
        r.subset       = subset;
        r.count        = total[RESULT_COUNT_W-1:0];
        r.marked_empty = marked_empty;
        r.dropped      = dropped_seen;
        r.tail         = tail;
        set_results_due.push_back(r);
    endfunction

    // works out the result list of one run from the current lists and mode
    task automatic predict_set_results();
        elem_list_t a_set;
        elem_list_t b_set;
        elem_list_t merged;
        int na;
        int nb;
        int ia;
        int ib;
        int k;
        a_set = mirror_a;
        b_set = mirror_b;
        na = len_a;
        nb = len_b;
        ia = 0;
        ib = 0;
        k = 0;
        case (cur_mode)
            OP_SUBSET:
            begin
                // one-to-one matching: a repeat in A needs its own partner in B
                while (ia < na && ib < nb && a_set[ia] >= b_set[ib])
                begin
                    if (a_set[ia] == b_set[ib])
                    begin
                        ia++;
                    end
                    ib++;
                end
                push_result('0, ia >= na, 0, 1'b1, 1'b1);
                return;
            end
            OP_UNION:
            begin
                if (cur_dedupe)
                begin
                    na = squeeze_repeats(mirror_a, len_a, a_set);
                    nb = squeeze_repeats(mirror_b, len_b, b_set);
                end
                // equal heads are emitted once and both pointers advance
                while (ia < na || ib < nb)
                begin
                    if (ib >= nb || (ia < na && a_set[ia] < b_set[ib]))
                    begin
                        merged[k] = a_set[ia];
                        ia++;
                    end
                    else if (ia >= na || b_set[ib] < a_set[ia])
                    begin
                        merged[k] = b_set[ib];
                        ib++;
                    end
                    else
                    begin
                        merged[k] = a_set[ia];
                        ia++;
                        ib++;
                    end
                    k++;
                end
            end
            OP_INTERSECT:
            begin
                while (ia < na && ib < nb)
                begin
                    if (a_set[ia] == b_set[ib])
                    begin
                        merged[k] = a_set[ia];
                        k++;
                        ia++;
                        ib++;
                    end
                    else if (b_set[ib] < a_set[ia])
                    begin
                        ib++;
                    end
                    else
                    begin
                        ia++;
                    end
                end
            end
            default:
            begin
                k = squeeze_repeats(mirror_a, len_a, merged);
            end
        endcase
        if (k == 0)
        begin
            push_result('0, 1'b0, 0, 1'b1, 1'b1);
        end
        for (int i = 0; i < k; i++)
        begin
            push_result(merged[i], 1'b0, k, 1'b0, i == k - 1);
        end
    endtask

    // offer one item and wait until the block takes it, then update the bench state
    task automatic send_item(input logic [ACTION_W-1:0] act, input elem_t val);
        int gap;
        // mostly random gaps, with back-to-back stretches now and then
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            gap = 0;
            burst_left = $urandom_range(5, 30);
        end
        else
        begin
            gap = $urandom_range(0, 10);
        end
        // start stays high across back-to-back items and only drops for a gap
        if (gap > 0 && start_high)
        begin
            start <= 1'b0;
            start_high = 1'b0;
        end
        repeat (gap) @(posedge clk);
        action <= act;
        value  <= val;
        start  <= 1'b1;
        start_high = 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        case (act)
            ACT_APPEND_A, ACT_APPEND_B:
            begin
                if ((act == ACT_APPEND_A ? len_a : len_b) >= DEPTH)
                begin
                    // a full list drops the item and the flag sticks until reset
                    dropped_seen = 1'b1;
                    appends_dropped++;
                end
                else if (act == ACT_APPEND_A)
                begin
                    mirror_a[len_a] = val;
                    len_a++;
                    appends_kept++;
                end
                else
                begin
                    mirror_b[len_b] = val;
                    len_b++;
                    appends_kept++;
                end
            end
            ACT_RUN:
            begin
                predict_set_results();
                runs_sent++;
            end
            default:
            begin
                // unused code, nothing happens
            end
        endcase
    endtask

    // wait until every owed result is in and the block has gone quiet
    task automatic settle();
        if (start_high)
        begin
            start <= 1'b0;
            start_high = 1'b0;
        end
        while (set_results_due.size() != 0 || busy) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // both registers are written back to back on an idle block
    task automatic apply_settings(input op_mode_t mode, input logic dedupe);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= REG_OP_MODE;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cur_mode = mode;
        cfg_index <= REG_DEDUPE;
        cfg_data  <= {1'b0, dedupe};
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cur_dedupe = dedupe;
        cfg_valid <= 1'b0;
        reg_writes += 2;
    endtask

    task automatic run_in_every_mode();
        apply_settings(OP_UNION, 1'b0);
        send_item(ACT_RUN, $urandom());
        apply_settings(OP_UNION, 1'b1);
        send_item(ACT_RUN, $urandom());
        apply_settings(OP_INTERSECT, 1'b1);
        send_item(ACT_RUN, $urandom());
        apply_settings(OP_SUBSET, 1'b0);
        send_item(ACT_RUN, $urandom());
        apply_settings(OP_DEDUPE, 1'b1);
        send_item(ACT_RUN, $urandom());
    endtask

    // next element for a list: mostly ascending from its tail, sometimes out of order
    function automatic elem_t pick_append(input elem_list_t lst, input int n);
        longint cand;
        cand = (n > 0) ? longint'(lst[n-1]) : longint'(VAL_MIN);
        case ($urandom_range(0, 7))
            0:
            begin
                return $urandom();
            end
            1, 2:
            begin
                // repeat of the current tail
            end
            3, 4, 5:
            begin
                cand += longint'($urandom_range(1, 40));
            end
            default:
            begin
                cand += longint'($urandom_range(0, 32'h3fff_ffff));
            end
        endcase
        if (cand > longint'(VAL_MAX))
        begin
            cand = longint'(VAL_MAX);
        end
        return elem_t'(cand);
    endfunction

    // empty lists: every mode gives a single empty result, empty A is a subset
    task automatic test_empty_lists();
        run_in_every_mode();
        send_item(ACT_UNUSED, $urandom());
    endtask

    // repeats in both lists, the most negative value and signed ordering
    task automatic test_repeats_and_signed_order();
        send_item(ACT_APPEND_A, -5);
        send_item(ACT_APPEND_A, -5);
        send_item(ACT_APPEND_B, VAL_MIN);
        send_item(ACT_APPEND_B, -5);
        // the second -5 of A has no partner in B yet
        apply_settings(OP_SUBSET, 1'b0);
        send_item(ACT_RUN, $urandom());
        send_item(ACT_APPEND_B, -5);
        run_in_every_mode();
        send_item(ACT_APPEND_A, 3);
        send_item(ACT_APPEND_B, 1);
        run_in_every_mode();
    endtask

    // mixed appends and runs under random settings, lists kept one short of full
    task automatic test_random_sequences();
        int effective;
        int runs_in_phase;
        int pick;
        effective = 0;
        runs_in_phase = 0;
        while (effective < RANDOM_ITEMS)
        begin
            if (runs_in_phase == 0)
            begin
                apply_settings(op_mode_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
                runs_in_phase = $urandom_range(3, 20);
            end
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                send_item(ACT_UNUSED, $urandom());
            end
            else if (pick < 20 && len_a < DEPTH - 1)
            begin
                send_item(ACT_APPEND_A, pick_append(mirror_a, len_a));
                effective++;
            end
            else if (pick < 36 && len_b < DEPTH - 1)
            begin
                send_item(ACT_APPEND_B, pick_append(mirror_b, len_b));
                effective++;
            end
            else
            begin
                send_item(ACT_RUN, $urandom());
                effective++;
                runs_in_phase--;
            end
        end
    endtask

    // top both lists up with the largest value, then push past the end of each
    task automatic test_full_lists();
        while (len_a < DEPTH) send_item(ACT_APPEND_A, VAL_MAX);
        while (len_b < DEPTH) send_item(ACT_APPEND_B, VAL_MAX);
        run_in_every_mode();
        send_item(ACT_APPEND_A, $urandom());
        send_item(ACT_APPEND_B, $urandom());
        for (int i = 0; i < 6; i++)
        begin
            send_item($urandom_range(0, 1) ? ACT_APPEND_A : ACT_APPEND_B, $urandom());
        end
        run_in_every_mode();
    endtask

    initial
    begin
        start     <= 1'b0;
        action    <= ACT_APPEND_A;
        value     <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_OP_MODE;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        for (int i = 0; i < 2 * DEPTH; i++)
        begin
            mirror_a[i] = '0;
            mirror_b[i] = '0;
        end
        cur_mode     = OP_UNION;
        cur_dedupe   = 1'b0;
        dropped_seen = 1'b0;
        start_high   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_lists();
        test_repeats_and_signed_order();
        test_random_sequences();
        test_full_lists();

        // everything owed has arrived; leave room for anything stray to show up
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d runs, %0d appends (%0d dropped when full), %0d register writes",
                 runs_sent, appends_kept, appends_dropped, reg_writes);
        $display("checked %0d streamed results, %0d mismatches", results_checked, fail_count);
        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
